FILE: rtl/limit_order_book_matcher_top_defines.svh
// Assertion macros used by the order book top level.
`ifndef LIMIT_ORDER_BOOK_MATCHER_TOP_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_TOP_DEFINES_SVH

// Property that holds on every clock edge outside reset.
`define LOB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked on the next clock edge.
`define LOB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/lob_pkg.sv
// Package with the order book types, constants and memory entry layout.
package lob_pkg;
  localparam int NumSlots = 256;
  localparam int SlotW = $clog2(NumSlots);
  localparam int CntW = SlotW + 1;
  localparam logic [8:0] MatchMax = 9'd511;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_MODIFY = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_VOLUME = 2'd3
  } cmd_t;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] id;
    logic [31:0] arrival;
  } slot_t;

  localparam int SlotBits = $bits(slot_t);
endpackage

FILE: rtl/limit_order_book_matcher_top.sv
// Top level of the limit order book with price-time matching.
//
// Usage: one request enters on the in_ channel (valid/stall) and carries a
// command: submit, modify quantity, lookup or volume at a level. Every
// request produces exactly one result on the out_ channel; fields that a
// command does not set are zero.
// The resting orders sit in one synchronous RAM of NumSlots entries; a flop
// vector of valid bits marks occupied entries. Each request walks the table
// one entry per cycle through the RAM read port, with registered read data.
// Volume and modify to zero take one scan; lookup and a nonzero modify take
// one scan, or two when the id is not found on the buy side. The apply and
// done states follow. A submit takes one scan and one apply state per trade,
// and one more scan, apply and rest state when a remainder is left. One
// request is processed at a time; in_stall is high while a request is in
// flight.
// The result waits in an output register. When out_stall holds a result
// there, the next finished result waits in the done state, and in_stall
// stays high until the output register takes it.
// Reset (rst_n low, synchronous) empties the book at once by clearing all
// valid bits and zeroes the arrival counter; no clearing pass is needed.
module limit_order_book_matcher_top
  import lob_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_side,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_order_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_match_count,
  output logic        out_found,
  output logic        out_found_side,
  output logic [31:0] out_found_price,
  output logic [31:0] out_found_quantity,
  output logic [31:0] out_level_volume,
  output logic        out_book_full
);
`include "limit_order_book_matcher_top_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_REST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Request registers.
  cmd_t        cmd_r;
  logic        side_r;
  logic [31:0] price_r, qty_r, id_r;

  // Scan control: rd_idx_r is the address issued, chk_* the entry returned.
  logic [CntW-1:0]  rd_idx_r, rd_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [SlotW-1:0] chk_idx_r, chk_idx_nxt;
  logic             pass_r, pass_nxt;   // lookup/modify: 0 buy pass, 1 sell pass

  // Scan results.
  logic             hit_r, hit_nxt;
  logic [SlotW-1:0] hit_idx_r, hit_idx_nxt;
  slot_t            hit_ent_r, hit_ent_nxt;
  logic             free_r, free_nxt;
  logic [SlotW-1:0] free_idx_r, free_idx_nxt;
  logic [32:0]      sum_r, sum_nxt;
  logic [31:0]      left_r, left_nxt;
  logic [8:0]       trades_r, trades_nxt;
  logic             found_r, found_nxt;
  logic [31:0]      arr_r, arr_nxt;

  logic [NumSlots-1:0] valid_r, valid_nxt;

  // Output register.
  logic        ovld_r, ovld_nxt;
  logic [8:0]  o_mc_r, o_mc_nxt;
  logic        o_f_r, o_f_nxt, o_fs_r, o_fs_nxt, o_bf_r, o_bf_nxt;
  logic [31:0] o_fp_r, o_fp_nxt, o_fq_r, o_fq_nxt, o_lv_r, o_lv_nxt;

  // RAM port.
  logic             we;
  logic [SlotW-1:0] waddr;
  slot_t            wdata, rdata;
  logic [SlotBits-1:0] rdata_bits;

  lob_ram #(.Width(SlotBits), .Depth(NumSlots)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx_r[SlotW-1:0]),
    .rdata (rdata_bits)
  );
  assign rdata = slot_t'(rdata_bits);

  logic accept_in;
  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // Compare for the submit search: does the returned entry cross and beat
  // the current best by price, then by age, then by lower index.
  logic        ent_vld, crosses, better;
  logic [31:0] age_new, age_best;
  always_comb begin
    ent_vld  = chk_vld_r && valid_r[chk_idx_r];
    crosses  = (rdata.side != side_r) &&
               (side_r ? (rdata.price >= price_r) : (rdata.price <= price_r));
    age_new  = arr_r - rdata.arrival;
    age_best = arr_r - hit_ent_r.arrival;
    if (!hit_r) begin
      better = 1'b1;
    end else if (rdata.price != hit_ent_r.price) begin
      better = side_r ? (rdata.price > hit_ent_r.price) : (rdata.price < hit_ent_r.price);
    end else begin
      better = age_new > age_best;
    end
  end

  logic        scan_end;
  logic [31:0] trade_q;
  logic [31:0] hit_rem;
  assign scan_end = chk_vld_r && (chk_idx_r == SlotW'(NumSlots - 1));
  assign trade_q  = (left_r < hit_ent_r.quantity) ? left_r : hit_ent_r.quantity;
  assign hit_rem  = hit_ent_r.quantity - trade_q;

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = rd_idx_r[SlotW-1:0];
    pass_nxt     = pass_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_ent_nxt  = hit_ent_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    sum_nxt      = sum_r;
    left_nxt     = left_r;
    trades_nxt   = trades_r;
    found_nxt    = found_r;
    arr_nxt      = arr_r;
    valid_nxt    = valid_r;
    we           = 1'b0;
    waddr        = hit_idx_r;
    wdata        = hit_ent_r;
    ovld_nxt     = ovld_r && out_stall;
    o_mc_nxt = o_mc_r; o_f_nxt = o_f_r; o_fs_nxt = o_fs_r; o_bf_nxt = o_bf_r;
    o_fp_nxt = o_fp_r; o_fq_nxt = o_fq_r; o_lv_nxt = o_lv_r;

    case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          state_nxt  = ST_SCAN;
          rd_idx_nxt = '0;
          pass_nxt   = 1'b0;
          hit_nxt    = 1'b0;
          sum_nxt    = '0;
          left_nxt   = in_quantity;
          trades_nxt = '0;
          found_nxt  = 1'b0;
          // Zero quantity submit does nothing.
          if (cmd_t'(in_command) == CMD_SUBMIT && in_quantity == '0) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_idx_r != CntW'(NumSlots)) begin
          chk_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end
        if (chk_vld_r) begin
          case (cmd_r)
            CMD_SUBMIT: begin
              if (ent_vld && crosses && better) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = chk_idx_r;
                hit_ent_nxt = rdata;
              end
            end
            CMD_VOLUME: begin
              if (ent_vld && rdata.side == side_r && rdata.price == price_r) begin
                sum_nxt = sum_r + {1'b0, rdata.quantity};
                if (sum_nxt[32]) sum_nxt = {1'b0, 32'hFFFF_FFFF};
              end
            end
            CMD_MODIFY: begin
              if (qty_r == '0) begin
                if (ent_vld && rdata.id == id_r) begin
                  valid_nxt[chk_idx_r] = 1'b0;
                  found_nxt = 1'b1;
                end
              end else if (!hit_r && ent_vld && rdata.side == pass_r && rdata.id == id_r) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = chk_idx_r;
                hit_ent_nxt = rdata;
              end
            end
            default: begin
              if (!hit_r && ent_vld && rdata.side == pass_r && rdata.id == id_r) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = chk_idx_r;
                hit_ent_nxt = rdata;
              end
            end
          endcase
        end
        if (scan_end) begin
          chk_vld_nxt = 1'b0;
          rd_idx_nxt  = '0;
          state_nxt   = ST_APPLY;
          if ((cmd_r == CMD_LOOKUP || (cmd_r == CMD_MODIFY && qty_r != '0)) &&
              !pass_r && !hit_nxt) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_APPLY: begin
        state_nxt = ST_DONE;
        case (cmd_r)
          CMD_SUBMIT: begin
            if (hit_r) begin
              we             = 1'b1;
              wdata.quantity = hit_rem;
              if (hit_rem == '0) valid_nxt[hit_idx_r] = 1'b0;
              left_nxt = left_r - trade_q;
              if (trades_r != MatchMax) trades_nxt = trades_r + 1'b1;
              hit_nxt = 1'b0;
              if (left_r != trade_q) state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_REST;
            end
          end
          CMD_MODIFY: begin
            if (qty_r != '0 && hit_r) begin
              we             = 1'b1;
              wdata.quantity = qty_r;
              found_nxt      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_REST: begin
        // Lowest free slot by priority search over the valid flops.
        free_nxt = 1'b0;
        free_idx_nxt = '0;
        for (int i = NumSlots - 1; i >= 0; i--) begin
          if (!valid_r[i]) begin
            free_nxt     = 1'b1;
            free_idx_nxt = SlotW'(i);
          end
        end
        if (free_nxt) begin
          we            = 1'b1;
          waddr         = free_idx_nxt;
          wdata.side    = side_r;
          wdata.price   = price_r;
          wdata.quantity = left_r;
          wdata.id      = id_r;
          wdata.arrival = arr_r;
          valid_nxt[free_idx_nxt] = 1'b1;
          arr_nxt = arr_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt = 1'b1;
          state_nxt = ST_IDLE;
          o_mc_nxt = (cmd_r == CMD_SUBMIT) ? trades_r : '0;
          o_bf_nxt = (cmd_r == CMD_SUBMIT) && (left_r != '0) && !free_r;
          o_lv_nxt = (cmd_r == CMD_VOLUME) ? sum_r[31:0] : '0;
          o_f_nxt  = (cmd_r == CMD_MODIFY) ? found_r :
                     (cmd_r == CMD_LOOKUP) ? hit_r : 1'b0;
          o_fs_nxt = (cmd_r == CMD_LOOKUP && hit_r) ? hit_ent_r.side : 1'b0;
          o_fp_nxt = (cmd_r == CMD_LOOKUP && hit_r) ? hit_ent_r.price : '0;
          o_fq_nxt = (cmd_r == CMD_LOOKUP && hit_r) ? hit_ent_r.quantity : '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      arr_r     <= '0;
      ovld_r    <= 1'b0;
      chk_vld_r <= 1'b0;
      rd_idx_r  <= '0;
      hit_r     <= 1'b0;
      free_r    <= 1'b1;
      pass_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      arr_r     <= arr_nxt;
      ovld_r    <= ovld_nxt;
      chk_vld_r <= chk_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
      hit_r     <= hit_nxt;
      free_r    <= (state_r == ST_IDLE) ? 1'b1 : free_nxt;
      pass_r    <= pass_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cmd_r   <= cmd_t'(in_command);
      side_r  <= in_side;
      price_r <= in_price;
      qty_r   <= in_quantity;
      id_r    <= in_order_id;
    end
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_ent_r  <= hit_ent_nxt;
    free_idx_r <= free_idx_nxt;
    sum_r      <= sum_nxt;
    left_r     <= left_nxt;
    trades_r   <= trades_nxt;
    o_mc_r <= o_mc_nxt; o_f_r <= o_f_nxt; o_fs_r <= o_fs_nxt; o_bf_r <= o_bf_nxt;
    o_fp_r <= o_fp_nxt; o_fq_r <= o_fq_nxt; o_lv_r <= o_lv_nxt;
  end

  assign out_valid          = ovld_r;
  assign out_match_count    = o_mc_r;
  assign out_found          = o_f_r;
  assign out_found_side     = o_fs_r;
  assign out_found_price    = o_fp_r;
  assign out_found_quantity = o_fq_r;
  assign out_level_volume   = o_lv_r;
  assign out_book_full      = o_bf_r;

  `LOB_ASSERT(a_state_onehot, $onehot(state_r), "state register not one-hot")
  `LOB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_match_count),
                   "stalled result changed")
  `LOB_ASSERT(a_stall_busy, in_stall == (state_r != ST_IDLE), "input stall mismatch")
  `LOB_ASSERT_NEXT(a_rest_bumps_arrival, state_r == ST_REST && free_nxt,
                   arr_r == $past(arr_r) + 32'd1, "arrival not advanced on rest")
endmodule

FILE: rtl/lob_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lob_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the limit order book matcher with price-time priority.
`timescale 1ns / 1ps

module tb_top;
  import lob_pkg::*;

  // One request on the in_ channel and one result on the out_ channel.
  typedef struct {
    cmd_t        cmd;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] id;
  } order_req_t;

  typedef struct {
    logic [8:0]  match_count;
    logic        found;
    logic        found_side;
    logic [31:0] found_price;
    logic [31:0] found_qty;
    logic [31:0] level_volume;
    logic        book_full;
  } book_res_t;

  // A directed row carries the request and, where it is obvious, the result typed in.
  typedef struct {
    order_req_t req;
    bit         typed;
    book_res_t  res;
  } directed_row_t;

  localparam int unsigned MaxU = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_SUBMIT;
  logic        in_side = 1'b0;
  logic [31:0] in_price = '0;
  logic [31:0] in_quantity = '0;
  logic [31:0] in_order_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_match_count;
  logic        out_found;
  logic        out_found_side;
  logic [31:0] out_found_price;
  logic [31:0] out_found_quantity;
  logic [31:0] out_level_volume;
  logic        out_book_full;

  limit_order_book_matcher_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_side(in_side), .in_price(in_price), .in_quantity(in_quantity),
    .in_order_id(in_order_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_match_count(out_match_count), .out_found(out_found),
    .out_found_side(out_found_side), .out_found_price(out_found_price),
    .out_found_quantity(out_found_quantity), .out_level_volume(out_level_volume),
    .out_book_full(out_book_full)
  );

  always #5 clk = ~clk;

  // Shadow copy of the order table kept by the predictor.
  logic        book_valid [NumSlots];
  logic        book_side  [NumSlots];
  logic [31:0] book_price [NumSlots];
  logic [31:0] book_qty   [NumSlots];
  logic [31:0] book_id    [NumSlots];
  logic [31:0] book_stamp [NumSlots];
  logic [31:0] stamp_counter;

  book_res_t   pending_results[$];
  int          error_count = 0;
  int          send_idle_pct = 10;
  int          recv_stall_pct = 47;

  // Best crossing entry on the opposite side: best price, then oldest, then lowest index.
  function automatic int best_resting(logic side, logic [31:0] limit);
    int          best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < NumSlots; i++) begin
      if (!book_valid[i] || book_side[i] == side) continue;
      if (side == 1'b0 ? (book_price[i] > limit) : (book_price[i] < limit)) continue;
      age = stamp_counter - book_stamp[i];
      if (best < 0) begin
        best = i;
        best_age = age;
      end else if (book_price[i] != book_price[best]) begin
        if (side == 1'b0 ? (book_price[i] < book_price[best])
                         : (book_price[i] > book_price[best])) begin
          best = i;
          best_age = age;
        end
      end else if (age > best_age) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  // First entry with the id, buy side searched before sell side.
  function automatic int locate_order(logic [31:0] id);
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < NumSlots; i++)
        if (book_valid[i] && book_side[i] == s[0] && book_id[i] == id) return i;
    return -1;
  endfunction

  // Applies one request to the shadow book and returns the result it must produce.
  function automatic book_res_t apply_to_book(order_req_t r);
    book_res_t   res;
    logic [31:0] left;
    logic [31:0] fill;
    logic [32:0] sum;
    int          s;
    int          free_slot;
    res = '{default: '0};
    case (r.cmd)
      CMD_SUBMIT: begin
        left = r.qty;
        while (left != 0) begin
          s = best_resting(r.side, r.price);
          if (s < 0) break;
          fill = (left < book_qty[s]) ? left : book_qty[s];
          left -= fill;
          book_qty[s] -= fill;
          if (res.match_count != MatchMax) res.match_count++;
          if (book_qty[s] == 0) book_valid[s] = 1'b0;
        end
        if (left != 0) begin
          free_slot = -1;
          for (int i = 0; i < NumSlots; i++)
            if (!book_valid[i]) begin
              free_slot = i;
              break;
            end
          if (free_slot < 0) begin
            res.book_full = 1'b1;
          end else begin
            book_valid[free_slot] = 1'b1;
            book_side[free_slot]  = r.side;
            book_price[free_slot] = r.price;
            book_qty[free_slot]   = left;
            book_id[free_slot]    = r.id;
            book_stamp[free_slot] = stamp_counter;
            stamp_counter++;
          end
        end
      end
      CMD_MODIFY: begin
        if (r.qty == 0) begin
          for (int i = 0; i < NumSlots; i++)
            if (book_valid[i] && book_id[i] == r.id) begin
              book_valid[i] = 1'b0;
              res.found = 1'b1;
            end
        end else begin
          s = locate_order(r.id);
          if (s >= 0) begin
            book_qty[s] = r.qty;
            res.found = 1'b1;
          end
        end
      end
      CMD_LOOKUP: begin
        s = locate_order(r.id);
        if (s >= 0) begin
          res.found       = 1'b1;
          res.found_side  = book_side[s];
          res.found_price = book_price[s];
          res.found_qty   = book_qty[s];
        end
      end
      default: begin
        sum = '0;
        for (int i = 0; i < NumSlots; i++)
          if (book_valid[i] && book_side[i] == r.side && book_price[i] == r.price) begin
            sum += book_qty[i];
            if (sum > MaxU) sum = MaxU;
          end
        res.level_volume = sum[31:0];
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Drives one request, honoring the sender idle rate, and records the expected
  // result once the request is accepted.
  task automatic send_request(order_req_t r, bit typed = 1'b0,
                              book_res_t typed_res = '{default: '0});
    book_res_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= r.cmd;
    in_side     <= r.side;
    in_price    <= r.price;
    in_quantity <= r.qty;
    in_order_id <= r.id;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = apply_to_book(r);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
  endtask

  // Receiver: random stall, and every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    book_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        e = pending_results.pop_front();
        if (out_match_count !== e.match_count)
          report_mismatch($sformatf("match_count %0d, expected %0d",
                                    out_match_count, e.match_count));
        if (out_found !== e.found)
          report_mismatch($sformatf("found %0b, expected %0b", out_found, e.found));
        if (out_found_side !== e.found_side)
          report_mismatch($sformatf("found_side %0b, expected %0b",
                                    out_found_side, e.found_side));
        if (out_found_price !== e.found_price)
          report_mismatch($sformatf("found_price %0h, expected %0h",
                                    out_found_price, e.found_price));
        if (out_found_quantity !== e.found_qty)
          report_mismatch($sformatf("found_quantity %0h, expected %0h",
                                    out_found_quantity, e.found_qty));
        if (out_level_volume !== e.level_volume)
          report_mismatch($sformatf("level_volume %0h, expected %0h",
                                    out_level_volume, e.level_volume));
        if (out_book_full !== e.book_full)
          report_mismatch($sformatf("book_full %0b, expected %0b",
                                    out_book_full, e.book_full));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Random request with prices clustered so that buys and sells cross often, a small
  // id pool so that modify and lookup hit and duplicates occur, and occasional
  // full-range values so that every field bit toggles.
  function automatic order_req_t random_request();
    order_req_t r;
    int         pick;
    pick = $urandom_range(99);
    r.cmd = (pick < 50) ? CMD_SUBMIT : (pick < 65) ? CMD_MODIFY :
            (pick < 85) ? CMD_LOOKUP : CMD_VOLUME;
    r.side = 1'($urandom_range(1));
    pick = $urandom_range(99);
    r.price = (pick < 90) ? 32'd100 + $urandom_range(7) :
              (pick < 95) ? ($urandom_range(1) ? MaxU : 32'd0) : $urandom;
    pick = $urandom_range(99);
    r.qty = (pick < 85) ? $urandom_range(1, 50) : (pick < 90) ? 32'd0 : $urandom;
    r.id = ($urandom_range(99) < 85) ? $urandom_range(40) : $urandom;
    return r;
  endfunction

  // Directed stimulus: empty book, extremes, saturation, every command, duplicate ids.
  directed_row_t directed_rows[] = '{
    // Lookup and volume on an empty book, and a zero-quantity submit: all zero.
    '{'{CMD_LOOKUP, 1'b0, 32'd0, 32'd0, 32'd5}, 1'b1, '{default: '0}},
    '{'{CMD_VOLUME, 1'b0, 32'd0, 32'd0, 32'd0}, 1'b1, '{default: '0}},
    '{'{CMD_SUBMIT, 1'b1, 32'd10, 32'd0, 32'd9}, 1'b1, '{default: '0}},
    // Two maximal buys rest at the top price; their volume saturates.
    '{'{CMD_SUBMIT, 1'b0, MaxU, MaxU, 32'd1}, 1'b1, '{default: '0}},
    '{'{CMD_SUBMIT, 1'b0, MaxU, MaxU, 32'd2}, 1'b1, '{default: '0}},
    '{'{CMD_VOLUME, 1'b0, MaxU, 32'd0, 32'd0}, 1'b1,
      '{9'd0, 1'b0, 1'b0, 32'd0, 32'd0, MaxU, 1'b0}},
    '{'{CMD_LOOKUP, 1'b0, 32'd0, 32'd0, 32'd1}, 1'b1,
      '{9'd0, 1'b1, 1'b0, MaxU, MaxU, 32'd0, 1'b0}},
    // A sell at price zero hits the earliest of the two buys.
    '{'{CMD_SUBMIT, 1'b1, 32'd0, 32'd10, 32'd3}, 1'b1,
      '{9'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{'{CMD_LOOKUP, 1'b0, 32'd0, 32'd0, 32'd1}, 1'b1,
      '{9'd0, 1'b1, 1'b0, MaxU, 32'hFFFF_FFF5, 32'd0, 1'b0}},
    // Modify to zero removes, a second try misses, a nonzero modify updates.
    '{'{CMD_MODIFY, 1'b0, 32'd0, 32'd0, 32'd2}, 1'b1,
      '{9'd0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{'{CMD_MODIFY, 1'b0, 32'd0, 32'd5, 32'd2}, 1'b1, '{default: '0}},
    '{'{CMD_MODIFY, 1'b1, 32'd0, 32'd7, 32'd1}, 1'b1,
      '{9'd0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{'{CMD_SUBMIT, 1'b1, 32'd0, 32'd20, 32'd4}, 1'b1,
      '{9'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}},
    '{'{CMD_LOOKUP, 1'b0, 32'd0, 32'd0, 32'd4}, 1'b1,
      '{9'd0, 1'b1, 1'b1, 32'd0, 32'd13, 32'd0, 1'b0}},
    // Duplicate id on the sell side, then a buy that crosses both.
    '{'{CMD_SUBMIT, 1'b1, 32'd0, 32'd4, 32'd4}, 1'b0, '{default: '0}},
    '{'{CMD_SUBMIT, 1'b0, 32'd5, 32'd15, 32'd6}, 1'b0, '{default: '0}},
    '{'{CMD_VOLUME, 1'b1, 32'd0, 32'd0, 32'd0}, 1'b0, '{default: '0}},
    '{'{CMD_SUBMIT, 1'b1, 32'd0, 32'd6, 32'd4}, 1'b0, '{default: '0}},
    '{'{CMD_MODIFY, 1'b0, 32'd0, MaxU, 32'd4}, 1'b0, '{default: '0}},
    '{'{CMD_LOOKUP, 1'b0, 32'd0, 32'd0, 32'd4}, 1'b0, '{default: '0}},
    '{'{CMD_MODIFY, 1'b0, 32'd0, 32'd0, 32'd4}, 1'b0, '{default: '0}},
    '{'{CMD_VOLUME, 1'b1, MaxU, 32'd0, MaxU}, 1'b0, '{default: '0}},
    '{'{CMD_LOOKUP, 1'b1, MaxU, MaxU, MaxU}, 1'b0, '{default: '0}}
  };

  initial begin
    order_req_t r;
    int         wait_cycles;
    for (int i = 0; i < NumSlots; i++) book_valid[i] = 1'b0;
    stamp_counter = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: light sender idling, heavy receiver stalls.
    foreach (directed_rows[k])
      send_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);
    repeat (260) send_request(random_request());

    // Second phase, roles swapped: fill the book with non-crossing levels until the
    // table is full and remainders are dropped, then sweep both sides.
    send_idle_pct  = 47;
    recv_stall_pct = 10;
    for (int n = 0; n < 270; n++) begin
      r.cmd   = CMD_SUBMIT;
      r.side  = n[0];
      r.price = (r.side ? 32'd2000 : 32'd1000) + $urandom_range(5);
      r.qty   = $urandom_range(1, 9);
      r.id    = 32'd1000 + n;
      send_request(r);
    end
    for (int n = 0; n < 6; n++) begin
      r = random_request();
      r.price = (r.side ? 32'd2000 : 32'd1000) + $urandom_range(5);
      send_request(r);
    end
    send_request('{CMD_SUBMIT, 1'b0, 32'd2005, MaxU, 32'd77});
    send_request('{CMD_SUBMIT, 1'b1, 32'd0, MaxU, 32'd78});

    // Last phase: no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (250) send_request(random_request());
    in_valid <= 1'b0;

    // Drain the outstanding results, then check that none is left.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (600) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
